@@ src/cbs_pkg.sv @@
`default_nettype none
package cbs_pkg;

    localparam int MAX_POINTS_DEF  = 4096;
    localparam int COORD_BITS_DEF  = 16;
    localparam int OUT_BITS        = 16;
    localparam int COUNT_OUT_BITS  = 13;
    localparam int CFG_BITS        = 16;
    localparam int APB_ADDR_BITS   = 5;
    localparam int APB_DATA_BITS   = 32;
    localparam int OUT_TDATA_BITS  = ((9 * OUT_BITS + COUNT_OUT_BITS + 2 + 7) / 8) * 8;

    localparam logic [2:0] REG_LENGTH_LIMIT  = 3'd0;
    localparam logic [2:0] REG_CENTRE_Y_LOW  = 3'd1;
    localparam logic [2:0] REG_CENTRE_Y_HIGH = 3'd2;
    localparam logic [2:0] REG_CENTRE_Z_LOW  = 3'd3;
    localparam logic [2:0] REG_HEIGHT_LOW    = 3'd4;

    localparam logic [CFG_BITS-1:0]        LENGTH_LIMIT_RST  = 16'd1280;
    localparam logic signed [CFG_BITS-1:0] CENTRE_Y_LOW_RST  = -16'sd1280;
    localparam logic signed [CFG_BITS-1:0] CENTRE_Y_HIGH_RST = 16'sd2048;
    localparam logic signed [CFG_BITS-1:0] CENTRE_Z_LOW_RST  = 16'sd51;
    localparam logic [CFG_BITS-1:0]        HEIGHT_LOW_RST    = 16'd51;

    typedef struct packed {
        logic [CFG_BITS-1:0]        length_limit;
        logic signed [CFG_BITS-1:0] centre_y_low;
        logic signed [CFG_BITS-1:0] centre_y_high;
        logic signed [CFG_BITS-1:0] centre_z_low;
        logic [CFG_BITS-1:0]        height_low;
    } cfg_t;

    typedef struct packed {
        logic [OUT_BITS-1:0]       centre_x;
        logic [OUT_BITS-1:0]       centre_y;
        logic [OUT_BITS-1:0]       centre_z;
        logic [OUT_BITS-1:0]       size_x;
        logic [OUT_BITS-1:0]       size_y;
        logic [OUT_BITS-1:0]       size_z;
        logic [OUT_BITS-1:0]       mean_x;
        logic [OUT_BITS-1:0]       mean_y;
        logic [OUT_BITS-1:0]       mean_z;
        logic [COUNT_OUT_BITS-1:0] point_count;
        logic                      kept;
        logic                      count_overflow;
    } result_t;

    typedef enum logic [1:0] {
        ST_ACCUM,
        ST_PREP,
        ST_DIV,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic accept;
        logic snap;
        logic prep;
        logic step;
        logic load;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

@@ src/cbs_regs.sv @@
`default_nettype none
module cbs_regs (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [cbs_pkg::APB_ADDR_BITS-1:0]    paddr,
    input  wire logic [cbs_pkg::APB_DATA_BITS-1:0]    pwdata,
    output logic      [cbs_pkg::APB_DATA_BITS-1:0]    prdata,
    output logic                                      pready,
    output cbs_pkg::cfg_t                             cfg
);

    cbs_pkg::cfg_t  cfg_reg;
    logic [2:0]     index;
    logic           wr_en;

    assign index  = paddr[cbs_pkg::APB_ADDR_BITS-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.length_limit  <= cbs_pkg::LENGTH_LIMIT_RST;
            cfg_reg.centre_y_low  <= cbs_pkg::CENTRE_Y_LOW_RST;
            cfg_reg.centre_y_high <= cbs_pkg::CENTRE_Y_HIGH_RST;
            cfg_reg.centre_z_low  <= cbs_pkg::CENTRE_Z_LOW_RST;
            cfg_reg.height_low    <= cbs_pkg::HEIGHT_LOW_RST;
        end else if (wr_en) begin
            case (index)
                cbs_pkg::REG_LENGTH_LIMIT:  cfg_reg.length_limit  <= pwdata[15:0];
                cbs_pkg::REG_CENTRE_Y_LOW:  cfg_reg.centre_y_low  <= pwdata[15:0];
                cbs_pkg::REG_CENTRE_Y_HIGH: cfg_reg.centre_y_high <= pwdata[15:0];
                cbs_pkg::REG_CENTRE_Z_LOW:  cfg_reg.centre_z_low  <= pwdata[15:0];
                cbs_pkg::REG_HEIGHT_LOW:    cfg_reg.height_low    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (index)
            cbs_pkg::REG_LENGTH_LIMIT:
                prdata = cbs_pkg::APB_DATA_BITS'(cfg_reg.length_limit);
            cbs_pkg::REG_CENTRE_Y_LOW:
                prdata = cbs_pkg::APB_DATA_BITS'($signed(cfg_reg.centre_y_low));
            cbs_pkg::REG_CENTRE_Y_HIGH:
                prdata = cbs_pkg::APB_DATA_BITS'($signed(cfg_reg.centre_y_high));
            cbs_pkg::REG_CENTRE_Z_LOW:
                prdata = cbs_pkg::APB_DATA_BITS'($signed(cfg_reg.centre_z_low));
            cbs_pkg::REG_HEIGHT_LOW:
                prdata = cbs_pkg::APB_DATA_BITS'(cfg_reg.height_low);
            default:
                prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

@@ src/cbs_ctrl.sv @@
`default_nettype none
module cbs_ctrl #(
    parameter int DIV_STEPS = cbs_pkg::COORD_BITS_DEF + $clog2(cbs_pkg::MAX_POINTS_DEF + 1)
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    input  wire logic       s_tlast,
    output logic            s_tready,
    input  cbs_pkg::status_t status,
    output cbs_pkg::cmd_t   cmd
);

    localparam int SCW = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    cbs_pkg::state_t state_reg, state_next;
    logic [SCW-1:0]  step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cbs_pkg::ST_ACCUM;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            cbs_pkg::ST_ACCUM: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                cmd.snap   = s_tvalid && s_tlast;
                if (s_tvalid && s_tlast) begin
                    state_next = cbs_pkg::ST_PREP;
                end
            end
            cbs_pkg::ST_PREP: begin
                cmd.prep   = 1'b1;
                step_next  = SCW'(DIV_STEPS - 1);
                state_next = cbs_pkg::ST_DIV;
            end
            cbs_pkg::ST_DIV: begin
                cmd.step = 1'b1;
                if (step_reg == '0) begin
                    state_next = cbs_pkg::ST_LOAD;
                end else begin
                    step_next = step_reg - SCW'(1);
                end
            end
            cbs_pkg::ST_LOAD: begin
                if (status.out_free) begin
                    cmd.load   = 1'b1;
                    state_next = cbs_pkg::ST_ACCUM;
                end
            end
            default: begin
                state_next = cbs_pkg::ST_ACCUM;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ src/cbs_datapath.sv @@
`default_nettype none
module cbs_datapath #(
    parameter int MAX_POINTS = cbs_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = cbs_pkg::COORD_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  cbs_pkg::cmd_t                      cmd,
    output cbs_pkg::status_t                   status,
    input  cbs_pkg::cfg_t                      cfg,
    input  wire logic signed [COORD_BITS-1:0]  point [3],
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output cbs_pkg::result_t                   result
);

    localparam int CB = COORD_BITS;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int SW = COORD_BITS + CW;
    localparam int KW = (COORD_BITS + 2 > cbs_pkg::CFG_BITS + 2) ?
                        COORD_BITS + 2 : cbs_pkg::CFG_BITS + 2;
    localparam logic signed [CB-1:0] COORD_MAXV = {1'b0, {(CB-1){1'b1}}};
    localparam logic signed [CB-1:0] COORD_MINV = {1'b1, {(CB-1){1'b0}}};

    // accumulators
    logic signed [CB-1:0] lo_reg [3];
    logic signed [CB-1:0] hi_reg [3];
    logic signed [SW-1:0] sum_reg [3];
    logic signed [CB-1:0] lo_next [3];
    logic signed [CB-1:0] hi_next [3];
    logic signed [SW-1:0] sum_next [3];
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 ovf_reg, ovf_next;
    logic                 acc_en;

    // snapshot of a finished cluster
    logic signed [CB-1:0] lo_snap_reg [3];
    logic signed [CB-1:0] hi_snap_reg [3];
    logic signed [SW-1:0] sum_snap_reg [3];
    logic [CW-1:0]        cnt_snap_reg;
    logic                 ovf_snap_reg;
    logic                 empty;

    // box stage
    logic [CB:0]          size_reg [3];
    logic signed [CB-1:0] centre_reg [3];
    logic [CB:0]          size_w [3];
    logic [CB:0]          centre_w [3];
    logic                 keep_reg;
    logic signed [KW-1:0] k_sx, k_sz, k_cy, k_cz;
    logic signed [KW-1:0] k_len, k_ylo, k_yhi, k_zlo, k_hlo;

    // restoring divider, one quotient bit per step
    logic [SW-1:0]        q_reg [3];
    logic [CW:0]          rem_reg [3];
    logic                 neg_reg [3];
    logic [SW-1:0]        q_next [3];
    logic [CW:0]          rem_next [3];
    logic [CW:0]          rem_sh [3];
    logic [SW-1:0]        mag_w [3];
    logic signed [SW-1:0] mean_w [3];

    logic                 out_valid_reg;
    cbs_pkg::result_t     result_reg;

    assign acc_en = cmd.accept && (cnt_reg < CW'(MAX_POINTS));
    assign empty  = (cnt_snap_reg == '0);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            lo_next[i]  = lo_reg[i];
            hi_next[i]  = hi_reg[i];
            sum_next[i] = sum_reg[i];
            if (acc_en) begin
                if (point[i] < lo_reg[i]) begin
                    lo_next[i] = point[i];
                end
                if (point[i] > hi_reg[i]) begin
                    hi_next[i] = point[i];
                end
                sum_next[i] = sum_reg[i] + SW'(point[i]);
            end
        end
        cnt_next = acc_en ? cnt_reg + CW'(1) : cnt_reg;
        ovf_next = ovf_reg || (cmd.accept && !acc_en);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (cmd.accept && cmd.snap)) begin
            for (int i = 0; i < 3; i++) begin
                lo_reg[i]  <= COORD_MAXV;
                hi_reg[i]  <= COORD_MINV;
                sum_reg[i] <= '0;
            end
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end else if (cmd.accept) begin
            for (int i = 0; i < 3; i++) begin
                lo_reg[i]  <= lo_next[i];
                hi_reg[i]  <= hi_next[i];
                sum_reg[i] <= sum_next[i];
            end
            cnt_reg <= cnt_next;
            ovf_reg <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.snap) begin
            for (int i = 0; i < 3; i++) begin
                lo_snap_reg[i]  <= lo_next[i];
                hi_snap_reg[i]  <= hi_next[i];
                sum_snap_reg[i] <= sum_next[i];
            end
            cnt_snap_reg <= cnt_next;
            ovf_snap_reg <= ovf_next;
        end
    end

    // size, centre and keep are registered in turn (size_reg, centre_reg, keep_reg), well inside the divide
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            size_w[i]   = (CB+1)'(hi_snap_reg[i]) - (CB+1)'(lo_snap_reg[i]);
            centre_w[i] = (CB+1)'(lo_snap_reg[i]) + (size_reg[i] >> 1);
        end
        k_sx  = KW'({1'b0, size_reg[0]});
        k_sz  = KW'({1'b0, size_reg[2]});
        k_cy  = KW'(centre_reg[1]);
        k_cz  = KW'(centre_reg[2]);
        k_len = KW'({1'b0, cfg.length_limit});
        k_hlo = KW'({1'b0, cfg.height_low});
        k_ylo = KW'($signed(cfg.centre_y_low));
        k_yhi = KW'($signed(cfg.centre_y_high));
        k_zlo = KW'($signed(cfg.centre_z_low));
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 3; i++) begin
            size_reg[i]   <= empty ? '0 : size_w[i];
            centre_reg[i] <= empty ? '0 : CB'(centre_w[i]);
        end
        keep_reg <= (k_sx < k_len) && (k_cy > k_ylo) && (k_cy < k_yhi)
                    && (k_cz > k_zlo) && (k_sz > k_hlo);
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag_w[i]    = sum_snap_reg[i][SW-1] ? SW'(-sum_snap_reg[i]) : SW'(sum_snap_reg[i]);
            rem_sh[i]   = {rem_reg[i][CW-1:0], q_reg[i][SW-1]};
            if (rem_sh[i] >= {1'b0, cnt_snap_reg}) begin
                rem_next[i] = rem_sh[i] - {1'b0, cnt_snap_reg};
                q_next[i]   = {q_reg[i][SW-2:0], 1'b1};
            end else begin
                rem_next[i] = rem_sh[i];
                q_next[i]   = {q_reg[i][SW-2:0], 1'b0};
            end
            if (empty) begin
                mean_w[i] = '0;
            end else if (neg_reg[i]) begin
                mean_w[i] = -$signed(q_reg[i]);
            end else begin
                mean_w[i] = $signed(q_reg[i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 3; i++) begin
            if (cmd.prep) begin
                q_reg[i]   <= mag_w[i];
                rem_reg[i] <= '0;
                neg_reg[i] <= sum_snap_reg[i][SW-1];
            end else if (cmd.step) begin
                q_reg[i]   <= q_next[i];
                rem_reg[i] <= rem_next[i];
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            result_reg.centre_x       <= cbs_pkg::OUT_BITS'(centre_reg[0]);
            result_reg.centre_y       <= cbs_pkg::OUT_BITS'(centre_reg[1]);
            result_reg.centre_z       <= cbs_pkg::OUT_BITS'(centre_reg[2]);
            result_reg.size_x         <= cbs_pkg::OUT_BITS'(size_reg[0]);
            result_reg.size_y         <= cbs_pkg::OUT_BITS'(size_reg[1]);
            result_reg.size_z         <= cbs_pkg::OUT_BITS'(size_reg[2]);
            result_reg.mean_x         <= cbs_pkg::OUT_BITS'(mean_w[0]);
            result_reg.mean_y         <= cbs_pkg::OUT_BITS'(mean_w[1]);
            result_reg.mean_z         <= cbs_pkg::OUT_BITS'(mean_w[2]);
            result_reg.point_count    <= cbs_pkg::COUNT_OUT_BITS'(cnt_snap_reg);
            result_reg.kept           <= keep_reg;
            result_reg.count_overflow <= ovf_snap_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign result          = result_reg;
    assign status.out_free = !out_valid_reg || out_ready;

endmodule
`default_nettype wire

@@ src/cluster_box_statistics_top.sv @@
`default_nettype none
// Bounding box and centroid of one cluster of points. Points arrive one per
// transaction on the slave stream, x, y and z signed with 8 fraction bits, and
// tlast marks the last point of a cluster. Points are taken at one per cycle;
// once the last point is in, the block holds off input while a shared-step
// restoring divider forms the three means one quotient bit per cycle, then
// places the result in the output register and takes points again, even while
// that result waits for m_axis_tready; a further result waits only if the
// previous one has not been taken. Points beyond MAX_POINTS in one cluster are
// dropped and reported through count_overflow. Thresholds for the kept flag
// are set over the APB port at byte addresses 0, 4, 8, 12 and 16.
module cluster_box_statistics_top #(
    parameter int MAX_POINTS = cbs_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = cbs_pkg::COORD_BITS_DEF
) (
    input  wire logic                                      aclk,
    input  wire logic                                      aresetn,
    input  wire logic                                      s_axis_tvalid,
    output logic                                           s_axis_tready,
    // point_x, point_y, point_z
    input  wire logic [((3*COORD_BITS+7)/8)*8-1:0]         s_axis_tdata,
    input  wire logic                                      s_axis_tlast,
    output logic                                           m_axis_tvalid,
    input  wire logic                                      m_axis_tready,
    // centre_x, centre_y, centre_z, size_x, size_y, size_z, mean_x, mean_y,
    // mean_z, point_count, kept, count_overflow
    output logic [cbs_pkg::OUT_TDATA_BITS-1:0]             m_axis_tdata,
    input  wire logic                                      psel,
    input  wire logic                                      penable,
    input  wire logic                                      pwrite,
    input  wire logic [cbs_pkg::APB_ADDR_BITS-1:0]         paddr,
    input  wire logic [cbs_pkg::APB_DATA_BITS-1:0]         pwdata,
    output logic      [cbs_pkg::APB_DATA_BITS-1:0]         prdata,
    output logic                                           pready
);

    localparam int DIV_STEPS = COORD_BITS + $clog2(MAX_POINTS + 1);
    localparam int OB        = cbs_pkg::OUT_BITS;
    localparam int RES_BITS  = 9 * OB + cbs_pkg::COUNT_OUT_BITS + 2;

    cbs_pkg::cfg_t              cfg;
    cbs_pkg::cmd_t              cmd;
    cbs_pkg::status_t           status;
    cbs_pkg::result_t           result;
    logic signed [COORD_BITS-1:0] point [3];
    logic [RES_BITS-1:0]        res_flat;

    assign point[0] = s_axis_tdata[COORD_BITS-1:0];
    assign point[1] = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
    assign point[2] = s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];

    assign res_flat = {result.count_overflow, result.kept, result.point_count,
                       result.mean_z, result.mean_y, result.mean_x,
                       result.size_z, result.size_y, result.size_x,
                       result.centre_z, result.centre_y, result.centre_x};
    assign m_axis_tdata = cbs_pkg::OUT_TDATA_BITS'(res_flat);

    cbs_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cbs_ctrl #(
        .DIV_STEPS (DIV_STEPS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_axis_tvalid),
        .s_tlast  (s_axis_tlast),
        .s_tready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    cbs_datapath #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .cfg       (cfg),
        .point     (point),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .result    (result)
    );

endmodule
`default_nettype wire
